/* rtl/core/nalsp_pkg.sv */
// ============================================================================
// nalsp_pkg: shared definitions for the Annex B NAL unit splitter
// Holds the length limit, the type codes and the result record.
// ============================================================================
package nalsp_pkg;

  // Longest unit that is passed on; the byte that reaches it ends the unit.
  localparam int MAX_UNIT_BYTES = 65536;
  localparam int LEN_W          = $clog2(MAX_UNIT_BYTES + 1);

  // Look-ahead window depth and the width of its fill count.
  localparam int HOLD_DEPTH = 3;
  localparam int CNT_W      = 2;

  localparam logic [4:0] TYPE_MASK      = 5'h1f;
  localparam logic [4:0] TYPE_DELIMITER = 5'h09;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_first;
    logic       unit_last;
    logic [4:0] unit_type;
    logic       overflow;
  } nalsp_result_t;

endpackage

/* rtl/core/annexb_nal_unit_splitter.sv */
// ============================================================================
// annexb_nal_unit_splitter: H.264 Annex B byte stream to NAL unit bytes
// Strips start codes, marks unit boundaries and types, drops delimiters when drop_delimiters is set.
// ============================================================================
// A payload byte is placed in the output register, or in the skid entry while
// that register is stalled, when the stream byte that releases it is accepted
// (three bytes of look-ahead sit in the window). Throughput: one stream byte
// per cycle while the skid entry is empty (in_stall low); a two-entry output
// stage (register plus skid) keeps the input moving while a result waits. Reset
// (rst_n low, synchronous) empties the window and output stage and sets drop_delimiters.
module annexb_nal_unit_splitter
  import nalsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: the drop_delimiters register.
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Stream byte requests.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  // Payload byte requests.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_unit_first,
  output logic       out_unit_last,
  output logic [4:0] out_unit_type,
  output logic       out_overflow
);

  // Look-ahead window, oldest byte at index zero, and its fill count.
  logic [7:0]       held_r   [HOLD_DEPTH];
  logic [7:0]       held_nxt [HOLD_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Unit tracking state.
  logic             inside_r, inside_nxt;
  logic             first_r, first_nxt;
  logic [4:0]       type_r, type_nxt;
  logic             disc_r, disc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             drop_r;

  // Output register and skid entry.
  nalsp_result_t    out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             res_valid;

  logic             in_accept;
  logic             out_take;
  logic             two_zeros;
  logic [LEN_W-1:0] len_inc;
  logic             cut;

  // The input stalls only while the skid entry is occupied, so a result can
  // wait in the output register without holding up the stream.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  // The two newest held bytes are both zero: a start code or a run of three
  // zeros completes if this byte is 01 or 00.
  always_comb begin
    two_zeros = 1'b0;
    case (cnt_r)
      2'd2:    two_zeros = (held_r[0] == 8'h00) && (held_r[1] == 8'h00);
      2'd3:    two_zeros = (held_r[1] == 8'h00) && (held_r[2] == 8'h00);
      default: two_zeros = 1'b0;
    endcase
  end

  assign len_inc = len_r + LEN_W'(1);
  assign cut     = len_inc >= LEN_W'(MAX_UNIT_BYTES);

  // One stream byte updates the window and unit state and may release one
  // payload byte. A payload byte always carries the first-byte flag and the
  // type that were in force before this byte, even when a new unit opens.
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      held_nxt[i] = held_r[i];
    end
    cnt_nxt    = cnt_r;
    inside_nxt = inside_r;
    first_nxt  = first_r;
    type_nxt   = type_r;
    disc_nxt   = disc_r;
    len_nxt    = len_r;
    res_valid  = 1'b0;
    res.out_byte   = held_r[0];
    res.unit_first = first_r;
    res.unit_last  = 1'b0;
    res.unit_type  = type_r & TYPE_MASK;
    res.overflow   = 1'b0;

    if (!inside_r) begin
      // Hunting: keep the last two bytes until 00 00 01 appears.
      if (two_zeros && in_data_byte == 8'h01) begin
        inside_nxt = 1'b1;
        cnt_nxt    = '0;
        first_nxt  = 1'b1;
        disc_nxt   = 1'b0;
        len_nxt    = '0;
        type_nxt   = '0;
      end else if (cnt_r >= 2'd2) begin
        held_nxt[0] = held_r[1];
        held_nxt[1] = in_data_byte;
        cnt_nxt     = 2'd2;
      end else begin
        held_nxt[cnt_r] = in_data_byte;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end else if (two_zeros && in_data_byte <= 8'h01) begin
      // The unit ends before the two zeros; a full window still holds its
      // final byte.
      if (cnt_r == 2'd3 && !disc_r) begin
        res_valid     = 1'b1;
        res.unit_last = 1'b1;
        first_nxt     = 1'b0;
      end
      if (in_data_byte == 8'h01) begin
        inside_nxt = 1'b1;
        cnt_nxt    = '0;
        first_nxt  = 1'b1;
        disc_nxt   = 1'b0;
        len_nxt    = '0;
        type_nxt   = '0;
      end else begin
        inside_nxt  = 1'b0;
        held_nxt[0] = 8'h00;
        held_nxt[1] = 8'h00;
        cnt_nxt     = 2'd2;
      end
    end else if (cnt_r < 2'd3) begin
      // Filling the window at the start of a unit. The first byte fixes the
      // type and whether the unit is a delimiter to be dropped.
      if (cnt_r == 2'd0) begin
        type_nxt = in_data_byte[4:0] & TYPE_MASK;
        if (drop_r && ((in_data_byte[4:0] & TYPE_MASK) == TYPE_DELIMITER)) begin
          disc_nxt = 1'b1;
        end
      end
      held_nxt[cnt_r] = in_data_byte;
      cnt_nxt         = cnt_r + 2'd1;
    end else begin
      // Full window: the oldest byte leaves, the new one enters.
      held_nxt[0] = held_r[1];
      held_nxt[1] = held_r[2];
      held_nxt[2] = in_data_byte;
      cnt_nxt     = 2'd3;
      if (!disc_r) begin
        len_nxt       = len_inc;
        res_valid     = 1'b1;
        res.unit_last = cut;
        res.overflow  = cut;
        first_nxt     = 1'b0;
        if (cut) begin
          disc_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      inside_r     <= 1'b0;
      first_r      <= 1'b0;
      type_r       <= '0;
      disc_r       <= 1'b0;
      len_r        <= '0;
      drop_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        drop_r <= cfg_wr_data;
      end

      if (in_accept) begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
          held_r[i] <= held_nxt[i];
        end
        cnt_r    <= cnt_nxt;
        inside_r <= inside_nxt;
        first_r  <= first_nxt;
        type_r   <= type_nxt;
        disc_r   <= disc_nxt;
        len_r    <= len_nxt;
      end

      // Output stage: the skid entry drains first; otherwise a new result
      // goes to the output register if it is free or being taken, and to
      // the skid entry if the output register is stalled.
      if (skid_valid_r) begin
        if (out_take) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (out_valid_r && !out_take) begin
        if (in_accept && res_valid) begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else begin
        out_valid_r <= in_accept && res_valid;
        out_r       <= res;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_r.out_byte;
  assign out_unit_first = out_r.unit_first;
  assign out_unit_last  = out_r.unit_last;
  assign out_unit_type  = out_r.unit_type;
  assign out_overflow   = out_r.overflow;

endmodule
